@@ rtl/core/fpl_pkg.sv @@
`default_nettype none
package fpl_pkg;

   localparam int HISTORY_DEPTH = 4;
   localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);

   localparam logic [31:0] PROCESS_MARGIN = 32'd50;
   localparam logic [19:0] SCALE_ONE      = 20'd65536;
   localparam logic [19:0] SCALE_MIN      = 20'd16384;
   localparam logic [19:0] SCALE_MAX      = 20'd524288;
   localparam logic [23:0] RATIO_MAX      = 24'hFFFFFF;
   localparam logic [15:0] BLANKS_MAX     = 16'hFFFF;
   localparam logic [31:0] SCALE_DIVISOR  = 32'd100;
   localparam logic [25:0] SCALE_ROUND    = 26'd50;

   localparam logic [1:0] REG_TICKS_BETWEEN_VBLS = 2'd0;
   localparam logic [1:0] REG_SPEED_MODE         = 2'd1;
   localparam logic [1:0] REG_AUX_SYNC_PRESENT   = 2'd2;

   localparam logic [1:0] SPEED_OFF  = 2'd0;
   localparam logic [1:0] SPEED_HALF = 2'd2;

   typedef struct packed {
      logic [31:0] origin;
      logic [63:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic        flipped;
      logic [15:0] sleep_ticks;
      logic [31:0] avg_ticks_per_vbl;
      logic [23:0] sync_ratio;
      logic [19:0] perf_scale;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/frame_pacing_limiter.sv @@
`default_nettype none
// Frame pacing limiter. Takes one vertical-blank word per handshake and returns one result
// word for each. For a blank whose origin matches the last one seen the result comes out
// through S_RATIO_GO and S_DONE, with the ratio division run first when the target tick
// count has been written since the last ratio was worked out. A flip uses one shared
// bit-serial restoring divider, with 32 steps for ticks per blank, 48 for the
// target/average ratio and 26 for the division by 100 in the scale update; the sum of the
// four history entries and the sleep delay follow the first division. The ratio division is
// skipped when the average is zero or the ratio saturates, and the scale division when the
// blank is not a flip or the target or the average is zero. The target times blank count
// product is formed by a serial shift-add while the first division runs. A new blank word
// can be taken in the same cycle as the result appears. The next blank word may be taken
// while a result still waits on rsp_ready. Configuration writes are always taken (csr_ready
// is high); write them only while no word is in flight.
module frame_pacing_limiter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fpl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fpl_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV_PER  = 4'd1;
   localparam logic [3:0] S_AVG      = 4'd2;
   localparam logic [3:0] S_DELAY    = 4'd3;
   localparam logic [3:0] S_RATIO_GO = 4'd4;
   localparam logic [3:0] S_RATIO    = 4'd5;
   localparam logic [3:0] S_SCALE_GO = 4'd6;
   localparam logic [3:0] S_SCALE    = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   localparam logic [5:0] STEPS_PER   = 6'd32;
   localparam logic [5:0] STEPS_RATIO = 6'd48;
   localparam logic [5:0] STEPS_SCALE = 6'd26;

   function automatic logic [19:0] clamp_scale(input logic [31:0] v);
      logic [19:0] r;
      if (v < {12'd0, fpl_pkg::SCALE_MIN}) begin
         r = fpl_pkg::SCALE_MIN;
      end else if (v > {12'd0, fpl_pkg::SCALE_MAX}) begin
         r = fpl_pkg::SCALE_MAX;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

   // configuration
   logic [31:0] tbv_ff;
   logic [1:0]  speed_ff;
   logic        aux_ff;

   // block state
   logic [31:0] last_origin_ff, last_origin_in;
   logic [63:0] last_time_ff, last_time_in;
   logic [15:0] blanks_ff, blanks_in;
   logic [31:0] history_ff [fpl_pkg::HISTORY_DEPTH];
   logic        hist_we;
   logic [31:0] hist_wdata;
   logic [fpl_pkg::HIST_IDX_W-1:0] slot_ff, slot_in;
   logic [31:0] average_ff, average_in;
   logic [19:0] scale_ff, scale_in;
   logic [23:0] ratio_ff, ratio_in;
   logic        stale_ff, stale_in;

   // sequencer and word registers
   logic [3:0]  state_ff, state_in;
   logic [31:0] origin_ff, origin_in;
   logic [63:0] now_ff, now_in;
   logic        flip_ff, flip_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [15:0] delay_ff, delay_in;
   logic [fpl_pkg::HIST_IDX_W-1:0] idx_ff, idx_in;
   logic [33:0] sum_ff, sum_in;

   // shared serial divider
   logic [47:0] dvd_ff, dvd_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;

   // serial multiplier
   logic [31:0] mcand_ff, mcand_in;
   logic [15:0] mplier_ff, mplier_in;
   logic [31:0] prod_ff, prod_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   fpl_pkg::rsp_type rsp_ff, rsp_in;

   logic        accept;
   logic [15:0] blanks_inc;
   logic [31:0] elapsed_new;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;
   logic [31:0] rem_step;
   logic [31:0] quo_step;
   logic [31:0] required;
   logic [31:0] delta;
   logic [15:0] delay_calc;
   logic        scale_go;
   logic        ratio_sat;
   logic [19:0] target;
   logic [25:0] acc;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign blanks_inc  = (blanks_ff < fpl_pkg::BLANKS_MAX) ? blanks_ff + 16'd1 : blanks_ff;
   assign elapsed_new = req_data.now_ticks[31:0] - last_time_ff[31:0];

   assign trial    = {rem_ff, dvd_ff[47]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign ge       = (trial >= {1'b0, dsr_ff});
   assign rem_step = ge ? diff[31:0] : trial[31:0];
   assign quo_step = {quo_ff[30:0], ge};

   assign required = (speed_ff == fpl_pkg::SPEED_HALF) ? {prod_ff[30:0], 1'b0} : prod_ff;
   assign delta    = required - elapsed_ff - fpl_pkg::PROCESS_MARGIN;
   assign delay_calc = ((speed_ff != fpl_pkg::SPEED_OFF) && !aux_ff && (delta != 32'd0)
                        && !delta[31]) ? delta[15:0] : 16'd0;

   assign scale_go  = flip_ff && (tbv_ff != 32'd0) && (average_ff != 32'd0);
   assign ratio_sat = ({8'd0, tbv_ff} >= {average_ff, 8'd0});
   assign target    = clamp_scale({8'd0, ratio_ff});
   assign acc = {scale_ff, 6'd0} + {2'd0, scale_ff, 4'd0} + {4'd0, scale_ff, 2'd0}
              + {6'd0, scale_ff} + {2'd0, target, 4'd0} - {6'd0, target} + fpl_pkg::SCALE_ROUND;

   always_comb begin
      state_in       = state_ff;
      last_origin_in = last_origin_ff;
      last_time_in   = last_time_ff;
      blanks_in      = blanks_ff;
      hist_we        = 1'b0;
      hist_wdata     = quo_step;
      slot_in        = slot_ff;
      average_in     = average_ff;
      scale_in       = scale_ff;
      ratio_in       = ratio_ff;
      stale_in       = stale_ff;
      origin_in      = origin_ff;
      now_in         = now_ff;
      flip_in        = flip_ff;
      elapsed_in     = elapsed_ff;
      delay_in       = delay_ff;
      idx_in         = idx_ff;
      sum_in         = sum_ff;
      dvd_in         = dvd_ff;
      dsr_in         = dsr_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      prod_in        = prod_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (csr_valid && (csr_index == fpl_pkg::REG_TICKS_BETWEEN_VBLS)) begin
         stale_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               origin_in  = req_data.origin;
               now_in     = req_data.now_ticks;
               blanks_in  = blanks_inc;
               flip_in    = (req_data.origin != last_origin_ff);
               elapsed_in = elapsed_new;
               delay_in   = 16'd0;
               dvd_in     = {elapsed_new, 16'd0};
               dsr_in     = {16'd0, blanks_inc};
               rem_in     = 32'd0;
               quo_in     = 32'd0;
               cnt_in     = STEPS_PER;
               mcand_in   = tbv_ff;
               mplier_in  = blanks_inc;
               prod_in    = 32'd0;
               state_in   = (req_data.origin != last_origin_ff) ? S_DIV_PER : S_RATIO_GO;
            end
         end
         S_DIV_PER: begin
            dvd_in    = {dvd_ff[46:0], 1'b0};
            rem_in    = rem_step;
            quo_in    = quo_step;
            cnt_in    = cnt_ff - 6'd1;
            mcand_in  = {mcand_ff[30:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[15:1]};
            prod_in   = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
            if (cnt_ff == 6'd1) begin
               hist_we  = 1'b1;
               slot_in  = slot_ff + fpl_pkg::HIST_IDX_W'(1);
               sum_in   = 34'd2;
               idx_in   = '0;
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            sum_in = sum_ff + {2'd0, history_ff[idx_ff]};
            idx_in = idx_ff + fpl_pkg::HIST_IDX_W'(1);
            if (idx_ff == fpl_pkg::HIST_IDX_W'(fpl_pkg::HISTORY_DEPTH - 1)) begin
               average_in = sum_in[33:2];
               state_in   = S_DELAY;
            end
         end
         S_DELAY: begin
            delay_in       = delay_calc;
            last_time_in   = now_ff + {48'd0, delay_calc};
            last_origin_in = origin_ff;
            blanks_in      = 16'd0;
            stale_in       = 1'b1;
            state_in       = S_RATIO_GO;
         end
         S_RATIO_GO: begin
            if (!stale_ff) begin
               state_in = S_DONE;
            end else begin
               stale_in = 1'b0;
               if (average_ff == 32'd0) begin
                  ratio_in = 24'd0;
                  state_in = scale_go ? S_SCALE_GO : S_DONE;
               end else if (ratio_sat) begin
                  ratio_in = fpl_pkg::RATIO_MAX;
                  state_in = scale_go ? S_SCALE_GO : S_DONE;
               end else begin
                  dvd_in   = {tbv_ff, 16'd0};
                  dsr_in   = average_ff;
                  rem_in   = 32'd0;
                  quo_in   = 32'd0;
                  cnt_in   = STEPS_RATIO;
                  state_in = S_RATIO;
               end
            end
         end
         S_RATIO: begin
            dvd_in = {dvd_ff[46:0], 1'b0};
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               ratio_in = quo_step[23:0];
               state_in = scale_go ? S_SCALE_GO : S_DONE;
            end
         end
         S_SCALE_GO: begin
            dvd_in   = {acc, 22'd0};
            dsr_in   = fpl_pkg::SCALE_DIVISOR;
            rem_in   = 32'd0;
            quo_in   = 32'd0;
            cnt_in   = STEPS_SCALE;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            dvd_in = {dvd_ff[46:0], 1'b0};
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               scale_in = clamp_scale(quo_step);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.flipped           = flip_ff;
               rsp_in.sleep_ticks       = delay_ff;
               rsp_in.avg_ticks_per_vbl = average_ff;
               rsp_in.sync_ratio        = ratio_ff;
               rsp_in.perf_scale        = scale_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbv_ff   <= 32'd0;
         speed_ff <= fpl_pkg::SPEED_OFF;
         aux_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            fpl_pkg::REG_TICKS_BETWEEN_VBLS: tbv_ff   <= csr_data;
            fpl_pkg::REG_SPEED_MODE:         speed_ff <= csr_data[1:0];
            fpl_pkg::REG_AUX_SYNC_PRESENT:   aux_ff   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fpl_pkg::HISTORY_DEPTH; i++) begin
            history_ff[i] <= 32'd0;
         end
      end else if (hist_we) begin
         history_ff[slot_ff] <= hist_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         last_origin_ff <= 32'd0;
         last_time_ff   <= 64'd0;
         blanks_ff      <= 16'd0;
         slot_ff        <= '0;
         average_ff     <= 32'd0;
         scale_ff       <= fpl_pkg::SCALE_ONE;
         ratio_ff       <= 24'd0;
         stale_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_origin_ff <= last_origin_in;
         last_time_ff   <= last_time_in;
         blanks_ff      <= blanks_in;
         slot_ff        <= slot_in;
         average_ff     <= average_in;
         scale_ff       <= scale_in;
         ratio_ff       <= ratio_in;
         stale_ff       <= stale_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      origin_ff  <= origin_in;
      now_ff     <= now_in;
      flip_ff    <= flip_in;
      elapsed_ff <= elapsed_in;
      delay_ff   <= delay_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      dvd_ff     <= dvd_in;
      dsr_ff     <= dsr_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

endmodule
`default_nettype wire
